// ----- design/adl_pkg.sv -----
// Shared constants, status codes and the frame snapshot type of the Adler-32 frame checker.
`timescale 1ns / 1ps
`default_nettype none
package adl_pkg;

	localparam int MAX_FRAME_LEN = 65536;
	localparam int CNT_W = $clog2(MAX_FRAME_LEN + 1);
	localparam int WIDE_W = ((CNT_W > 32) ? CNT_W : 32) + 2;
	localparam int HDR_BYTES = 4;

	localparam logic [16:0] ADLER_MOD = 17'd65521;
	localparam logic [CNT_W-1:0] MAX_LEN_C = CNT_W'(MAX_FRAME_LEN);
	localparam logic [CNT_W-1:0] MIN_FRAME = CNT_W'(10);
	localparam logic [CNT_W-1:0] HDR_LEN = CNT_W'(HDR_BYTES);
	localparam logic signed [WIDE_W-1:0] MIN_NAME = WIDE_W'(2);
	localparam logic signed [WIDE_W-1:0] TRAILER_LEN = WIDE_W'(8);

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SHORT    = 2'd1,
		ST_MISMATCH = 2'd2,
		ST_BAD_NAME = 2'd3
	} status_t;

	typedef struct packed {
		logic [15:0]      sum_high;
		logic [15:0]      sum_low;
		logic [31:0]      expected;
		logic [31:0]      header;
		logic [CNT_W-1:0] len;
	} frame_snap_t;

endpackage
`default_nettype wire

// ----- design/adl_accum.sv -----
// Running Adler-32 sums, four-byte tail delay line, header word and byte counter of one frame.
`timescale 1ns / 1ps
`default_nettype none
module adl_accum (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic [7:0]         data_byte,
	input  wire logic               last,
	output adl_pkg::frame_snap_t    snap
);

	logic [15:0]                 sum_low_q;
	logic [15:0]                 sum_high_q;
	logic [adl_pkg::CNT_W-1:0]   count_q;
	logic [7:0]                  tail_q [4];
	logic [31:0]                 header_q;

	logic [16:0]                 low_add;
	logic [16:0]                 high_add;
	logic [15:0]                 low_n;
	logic [15:0]                 high_n;
	logic                        in_header;
	logic [adl_pkg::CNT_W-1:0]   count_n;
	logic [31:0]                 header_n;

	always_comb begin
		in_header = count_q < adl_pkg::HDR_LEN;
		low_add = {1'b0, sum_low_q} + {9'b0, tail_q[0]};
		if (low_add >= adl_pkg::ADLER_MOD) begin
			low_add = low_add - adl_pkg::ADLER_MOD;
		end
		high_add = {1'b0, sum_high_q} + low_add;
		if (high_add >= adl_pkg::ADLER_MOD) begin
			high_add = high_add - adl_pkg::ADLER_MOD;
		end
		if (in_header) begin
			low_n = sum_low_q;
			high_n = sum_high_q;
			header_n = {header_q[23:0], data_byte};
		end else begin
			low_n = low_add[15:0];
			high_n = high_add[15:0];
			header_n = header_q;
		end
		if (count_q < adl_pkg::MAX_LEN_C) begin
			count_n = count_q + 1'b1;
		end else begin
			count_n = count_q;
		end
		snap.sum_low = low_n;
		snap.sum_high = high_n;
		snap.expected = {tail_q[1], tail_q[2], tail_q[3], data_byte};
		snap.header = header_n;
		snap.len = count_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_low_q <= 16'd1;
			sum_high_q <= 16'd0;
			count_q <= '0;
			header_q <= '0;
			tail_q[0] <= '0;
			tail_q[1] <= '0;
			tail_q[2] <= '0;
			tail_q[3] <= '0;
		end else if (en) begin
			if (last) begin
				sum_low_q <= 16'd1;
				sum_high_q <= 16'd0;
				count_q <= '0;
				header_q <= '0;
				tail_q[0] <= '0;
				tail_q[1] <= '0;
				tail_q[2] <= '0;
				tail_q[3] <= '0;
			end else begin
				sum_low_q <= low_n;
				sum_high_q <= high_n;
				count_q <= count_n;
				header_q <= header_n;
				tail_q[0] <= tail_q[1];
				tail_q[1] <= tail_q[2];
				tail_q[2] <= tail_q[3];
				tail_q[3] <= data_byte;
			end
		end
	end

endmodule
`default_nettype wire

// ----- design/adl_frame_checker.sv -----
// Frame status check of the Adler-32 frame checker: length, checksum and name length tests.
`timescale 1ns / 1ps
`default_nettype none
module adl_frame_checker (
	input  wire adl_pkg::frame_snap_t snap,
	output adl_pkg::status_t          status,
	output logic [15:0]               payload,
	output logic [31:0]               computed
);

	logic signed [adl_pkg::WIDE_W-1:0] len_w;
	logic signed [adl_pkg::WIDE_W-1:0] name_w;
	logic signed [adl_pkg::WIDE_W-1:0] limit_w;
	logic signed [adl_pkg::WIDE_W-1:0] pay_w;

	always_comb begin
		computed = {snap.sum_high, snap.sum_low};
		len_w = $signed({{(adl_pkg::WIDE_W - adl_pkg::CNT_W){1'b0}}, snap.len});
		name_w = $signed({{(adl_pkg::WIDE_W - 32){snap.header[31]}}, snap.header});
		limit_w = len_w - adl_pkg::TRAILER_LEN;
		pay_w = limit_w - name_w;
		payload = 16'd0;
		if (snap.len < adl_pkg::MIN_FRAME) begin
			status = adl_pkg::ST_SHORT;
		end else if (computed != snap.expected) begin
			status = adl_pkg::ST_MISMATCH;
		end else if (name_w < adl_pkg::MIN_NAME || name_w > limit_w) begin
			status = adl_pkg::ST_BAD_NAME;
		end else begin
			status = adl_pkg::ST_OK;
			payload = pay_w[15:0];
		end
	end

endmodule
`default_nettype wire

// ----- design/adler32_frame_checker.sv -----
// Top level of the Adler-32 frame checker: input, frame state, status and output stages.
// The slave stream carries one frame byte per request in s_axis_tdata, with s_axis_tlast on
// the final byte of the frame. No outer length prefix is expected.
// Every byte but the trailing four is folded into the Adler-32 sums; the trailing four are
// the big-endian expected checksum and the first four the signed big-endian name length.
// One result request leaves on the master stream per frame, for the byte marked last only.
// A byte request is taken in every cycle in which the pipeline can move, so the sustained
// rate is one byte per cycle, set by the combinational update of the two modular sums.
// A frame's result goes from the input register via the snapshot register to m_axis_tvalid.
// When the receiver holds m_axis_tready low the result waits in the output register while
// the input register and the snapshot stage keep filling; s_axis_tready falls only once all
// three stages hold work.
// Reset clears the sums, counter, delay line, header word and every valid flag, so the next
// byte taken starts a new frame. After a last byte the frame state clears by itself.
// Frames longer than MAX_FRAME_LEN keep that value as their length.
`timescale 1ns / 1ps
`default_nettype none
module adler32_frame_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // data_byte
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [87:0]      m_axis_tdata    // status, name_length, payload_length, computed_checksum
);

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   last_s1;
	logic                   valid_s2;
	adl_pkg::frame_snap_t   snap_s2;
	adl_pkg::frame_snap_t   snap;
	logic                   out_valid_q;
	logic [87:0]            out_data_q;

	logic                   out_load;
	logic                   s2_load;
	logic                   s1_load;
	logic                   s1_move;

	logic [31:0]            computed;
	adl_pkg::status_t       status;
	logic [15:0]            payload;

	assign out_load = !out_valid_q || m_axis_tready;
	assign s2_load = !valid_s2 || out_load;
	assign s1_load = !valid_s1 || s2_load;
	assign s1_move = valid_s1 && s2_load;
	assign s_axis_tready = s1_load;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

	adl_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (s1_move),
		.data_byte (byte_s1),
		.last      (last_s1),
		.snap      (snap)
	);

	adl_frame_checker u_check (
		.snap     (snap_s2),
		.status   (status),
		.payload  (payload),
		.computed (computed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_load) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (s2_load) begin
				valid_s2 <= s1_move && last_s1;
			end
			if (out_load) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
		if (s1_move && last_s1) begin
			snap_s2 <= snap;
		end
		if (out_load && valid_s2) begin
			out_data_q <= {6'd0, computed, payload, snap_s2.header, status};
		end
	end

endmodule
`default_nettype wire
